// ----- rtl/static_range_minimum_query_unit_macros.svh -----
// Assertion macros shared by the checker.
`ifndef STATIC_RANGE_MINIMUM_QUERY_UNIT_MACROS_SVH
`define STATIC_RANGE_MINIMUM_QUERY_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("srmq assertion failed");

// Next-cycle implication, disabled during reset
`define SRMQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("srmq assertion failed");

`endif

// ----- rtl/srmq_pkg.sv -----
`default_nettype none
package srmq_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned BLOCK_SIZE   = 32;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned OFF_W        = 5;
  localparam int unsigned BLK_W        = 5;
  localparam int unsigned MAX_BLOCKS   = MAX_ELEMENTS / BLOCK_SIZE;
  localparam int unsigned LYR_W        = 3;
  localparam int unsigned NUM_LAYERS   = 6;
  localparam int unsigned ST_DEPTH     = NUM_LAYERS * MAX_BLOCKS;
  localparam int unsigned ST_AW        = LYR_W + BLK_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_B_START, S_B_RDJ, S_B_VJ, S_B_TOP, S_B_CMP, S_B_BLK,
    S_L_START, S_L_RD1, S_L_RD2, S_L_V1, S_L_V2, S_L_WR,
    S_Q_M1, S_Q_M2, S_Q_A, S_Q_B, S_Q_BC, S_Q_S1, S_Q_S2, S_Q_S3, S_Q_S4,
    S_OUT
  } srmq_state_e;

  typedef struct packed {
    srmq_state_e phase;
    logic        load;
    logic        cfg;
    logic        qstart;
  } srmq_cmd_t;

  typedef struct packed {
    logic built;
    logic q_err;
    logic q_single;
    logic q_sparse;
    logic stack_empty;
    logic pop;
    logic blk_last;
    logic start_single;
    logic more_blocks;
    logic layer_ok;
    logic more_pairs;
  } srmq_stat_t;

  // lowest set bit, 31 when empty
  function automatic logic [OFF_W-1:0] low_bit(input logic [BLOCK_SIZE-1:0] x);
    logic [OFF_W-1:0] p;
    p = OFF_W'(BLOCK_SIZE - 1);
    for (int i = BLOCK_SIZE - 1; i >= 0; i--) begin
      if (x[i]) p = OFF_W'(i);
    end
    return p;
  endfunction

  // highest set bit, 0 when empty
  function automatic logic [OFF_W-1:0] high_bit(input logic [BLOCK_SIZE-1:0] x);
    logic [OFF_W-1:0] p;
    p = '0;
    for (int i = 0; i < BLOCK_SIZE; i++) begin
      if (x[i]) p = OFF_W'(i);
    end
    return p;
  endfunction

  function automatic logic better(input logic [VALUE_WIDTH-1:0] a,
                                  input logic [VALUE_WIDTH-1:0] b,
                                  input logic sel_max);
    return sel_max ? (a > b) : (a < b);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/srmq_ctrl.sv -----
`default_nettype none
module srmq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               operation_i,
  input  wire logic               last_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               out_ready_i,
  input  wire srmq_pkg::srmq_stat_t stat_i,
  output logic                    in_ready_o,
  output logic                    cfg_ready_o,
  output logic                    out_valid_o,
  output srmq_pkg::srmq_cmd_t     cmd_o
);
  import srmq_pkg::*;

  srmq_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.phase = state_q;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg = 1'b1;
          if (stat_i.built) state_d = S_B_START;
        end else if (in_valid_i) begin
          if (operation_i == OP_QUERY) begin
            cmd_o.qstart = 1'b1;
            state_d      = S_Q_M1;
          end else begin
            cmd_o.load = 1'b1;
            if (last_i) state_d = S_B_START;
          end
        end
      end
      S_B_START: state_d = stat_i.start_single ? S_B_BLK : S_B_RDJ;
      S_B_RDJ:   state_d = S_B_VJ;
      S_B_VJ:    state_d = S_B_TOP;
      S_B_TOP: begin
        if (!stat_i.stack_empty) state_d = S_B_CMP;
        else state_d = stat_i.blk_last ? S_B_BLK : S_B_RDJ;
      end
      S_B_CMP: begin
        if (stat_i.pop) state_d = S_B_TOP;
        else state_d = stat_i.blk_last ? S_B_BLK : S_B_RDJ;
      end
      S_B_BLK:   state_d = stat_i.more_blocks ? S_B_START : S_L_START;
      S_L_START: state_d = stat_i.layer_ok ? S_L_RD1 : S_IDLE;
      S_L_RD1:   state_d = S_L_RD2;
      S_L_RD2:   state_d = S_L_V1;
      S_L_V1:    state_d = S_L_V2;
      S_L_V2:    state_d = S_L_WR;
      S_L_WR:    state_d = stat_i.more_pairs ? S_L_RD1 : S_L_START;
      S_Q_M1:    state_d = stat_i.q_err ? S_OUT : S_Q_M2;
      S_Q_M2:    state_d = stat_i.q_single ? S_OUT : S_Q_A;
      S_Q_A:     state_d = S_Q_B;
      S_Q_B:     state_d = S_Q_BC;
      S_Q_BC:    state_d = stat_i.q_sparse ? S_Q_S1 : S_OUT;
      S_Q_S1:    state_d = S_Q_S2;
      S_Q_S2:    state_d = S_Q_S3;
      S_Q_S3:    state_d = S_Q_S4;
      S_Q_S4:    state_d = S_OUT;
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/srmq_datapath.sv -----
`default_nettype none
module srmq_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire srmq_pkg::srmq_cmd_t                 cmd_i,
  input  wire logic [srmq_pkg::VALUE_WIDTH-1:0]    value_i,
  input  wire logic [srmq_pkg::IDX_W-1:0]          left_index_i,
  input  wire logic [srmq_pkg::CNT_W-1:0]          right_end_i,
  input  wire logic                                select_maximum_i,
  output srmq_pkg::srmq_stat_t                     stat_o,
  output logic [srmq_pkg::IDX_W-1:0]               result_index_o,
  output logic                                     error_o
);
  import srmq_pkg::*;

  // memories
  logic [VALUE_WIDTH-1:0] val_mem  [MAX_ELEMENTS];
  logic [BLOCK_SIZE-1:0]  mask_mem [MAX_ELEMENTS];
  logic [IDX_W-1:0]       st_mem   [ST_DEPTH];

  logic [VALUE_WIDTH-1:0] val_rdata_q;
  logic [BLOCK_SIZE-1:0]  mask_rdata_q;
  logic [IDX_W-1:0]       st_rdata_q;

  logic [IDX_W-1:0]       val_raddr, val_waddr, mask_raddr, mask_waddr;
  logic [ST_AW-1:0]       st_raddr, st_waddr;
  logic                   val_we, mask_we, st_we;
  logic [BLOCK_SIZE-1:0]  mask_wdata;
  logic [IDX_W-1:0]       st_wdata;

  // control registers
  logic                   sel_max_q, built_q;
  logic [CNT_W-1:0]       count_q;
  // build registers
  logic [BLK_W:0]         bi_q;
  logic [CNT_W-1:0]       j_q;
  logic [BLOCK_SIZE-1:0]  stack_q;
  logic [VALUE_WIDTH-1:0] vj_q;
  logic [LYR_W-1:0]       k_q;
  logic [BLK_W:0]         ii_q;
  logic [IDX_W-1:0]       idx1_q, idx2_q;
  // query registers
  logic [IDX_W-1:0]       l_q, last_q, best_idx_q, cand_q;
  logic [VALUE_WIDTH-1:0] best_val_q;
  logic                   err_q;

  // build helpers
  logic [CNT_W-1:0]       base, blk_end, end_w;
  logic [OFF_W-1:0]       top_pos;
  logic [BLOCK_SIZE-1:0]  top_bit, stack_push;
  logic                   push;
  logic [BLK_W:0]         m_blocks;
  logic [LYR_W-1:0]       k_prev;
  logic [BLK_W-1:0]       half;
  logic [BLK_W+1:0]       pow_k;

  assign base       = {bi_q, {OFF_W{1'b0}}};
  assign blk_end    = base + CNT_W'(BLOCK_SIZE);
  assign end_w      = (blk_end < count_q) ? blk_end : count_q;
  assign top_pos    = high_bit(stack_q);
  assign top_bit    = BLOCK_SIZE'(1) << top_pos;
  assign stack_push = stack_q | (BLOCK_SIZE'(1) << j_q[OFF_W-1:0]);
  assign m_blocks   = (BLK_W+1)'((count_q + CNT_W'(BLOCK_SIZE - 1)) >> OFF_W);
  assign k_prev     = k_q - LYR_W'(1);
  assign half       = BLK_W'(1) << k_prev;
  assign pow_k      = (BLK_W+2)'(1) << k_q;

  // query helpers
  logic [BLK_W-1:0]       lb, rb, lb1, span, rb_lo;
  logic [OFF_W-1:0]       off;
  logic [LYR_W-1:0]       w;
  logic [IDX_W-1:0]       a_idx, st_idx;
  logic                   take;
  logic [IDX_W-1:0]       c_idx;

  assign lb     = l_q[IDX_W-1:OFF_W];
  assign rb     = last_q[IDX_W-1:OFF_W];
  assign off    = l_q[OFF_W-1:0];
  assign lb1    = lb + BLK_W'(1);
  assign span   = rb - lb1;
  assign w      = LYR_W'(high_bit(BLOCK_SIZE'(span)));
  assign rb_lo  = rb - (BLK_W'(1) << w);
  assign a_idx  = l_q + IDX_W'(low_bit(mask_rdata_q >> off));
  assign st_idx = st_rdata_q;

  // merge candidate: strictly better, or equal and further left
  assign c_idx = (cmd_i.phase == S_Q_BC) ? cand_q :
                 (cmd_i.phase == S_Q_S3) ? cand_q : cand_q;
  assign take  = better(val_rdata_q, best_val_q, sel_max_q) ||
                 ((val_rdata_q == best_val_q) && (c_idx < best_idx_q));

  assign push = ((cmd_i.phase == S_B_TOP) && (stack_q == '0)) ||
                ((cmd_i.phase == S_B_CMP) && !stat_o.pop);

  // status
  always_comb begin
    stat_o              = '0;
    stat_o.built        = built_q;
    stat_o.q_err        = err_q;
    stat_o.q_single     = (lb == rb);
    stat_o.q_sparse     = (lb1 < rb);
    stat_o.stack_empty  = (stack_q == '0);
    stat_o.pop          = (stack_q != '0) && better(vj_q, val_rdata_q, sel_max_q);
    stat_o.blk_last     = ((j_q + CNT_W'(1)) == end_w);
    stat_o.start_single = (count_q == (base + CNT_W'(1)));
    stat_o.more_blocks  = (blk_end < count_q);
    stat_o.layer_ok     = (pow_k <= (BLK_W+2)'(m_blocks));
    stat_o.more_pairs   = ((BLK_W+2)'(ii_q) + (BLK_W+2)'(1) + pow_k) <=
                          (BLK_W+2)'(m_blocks);
  end

  // memory port selection
  always_comb begin
    val_we     = 1'b0;
    val_waddr  = built_q ? '0 : count_q[IDX_W-1:0];
    val_raddr  = j_q[IDX_W-1:0];
    mask_we    = 1'b0;
    mask_waddr = j_q[IDX_W-1:0];
    mask_wdata = stack_push;
    mask_raddr = last_q;
    st_we      = 1'b0;
    st_waddr   = {k_q, ii_q[BLK_W-1:0]};
    st_wdata   = better(val_rdata_q, best_val_q, sel_max_q) ? idx2_q : idx1_q;
    st_raddr   = {k_prev, ii_q[BLK_W-1:0]};
    if (cmd_i.load) val_we = built_q || (count_q < CNT_W'(MAX_ELEMENTS));
    case (cmd_i.phase)
      S_B_START: begin
        mask_we    = 1'b1;
        mask_waddr = base[IDX_W-1:0];
        mask_wdata = BLOCK_SIZE'(1);
      end
      S_B_TOP:   val_raddr = {bi_q[BLK_W-1:0], top_pos};
      S_B_BLK: begin
        st_we    = 1'b1;
        st_waddr = {LYR_W'(0), bi_q[BLK_W-1:0]};
        st_wdata = {bi_q[BLK_W-1:0], low_bit(stack_q)};
      end
      S_L_RD2:   st_raddr = {k_prev, ii_q[BLK_W-1:0] + half};
      S_L_V1:    val_raddr = idx1_q;
      S_L_V2:    val_raddr = idx2_q;
      S_L_WR:    st_we = 1'b1;
      S_Q_M2:    mask_raddr = {lb, {OFF_W{1'b1}}};
      S_Q_A:     val_raddr = a_idx;
      S_Q_B:     val_raddr = cand_q;
      S_Q_S1:    st_raddr = {w, lb1};
      S_Q_S2: begin
        st_raddr  = {w, rb_lo};
        val_raddr = st_idx;
      end
      S_Q_S3:    val_raddr = st_idx;
      default: ;
    endcase
    if (push) mask_we = 1'b1;
  end

  // memories, registered reads
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_waddr] <= value_i;
    if (mask_we) mask_mem[mask_waddr] <= mask_wdata;
    if (st_we) st_mem[st_waddr] <= st_wdata;
    val_rdata_q  <= val_mem[val_raddr];
    mask_rdata_q <= mask_mem[mask_raddr];
    st_rdata_q   <= st_mem[st_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_max_q <= 1'b0;
      built_q   <= 1'b0;
      count_q   <= '0;
    end else begin
      if (cmd_i.cfg) sel_max_q <= select_maximum_i;
      if (cmd_i.load) begin
        if (built_q) begin
          built_q <= 1'b0;
          count_q <= CNT_W'(1);
        end else if (count_q < CNT_W'(MAX_ELEMENTS)) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if ((cmd_i.phase == S_L_START) && !stat_o.layer_ok) built_q <= 1'b1;
    end
  end

  // build and query working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.phase)
      S_IDLE: begin
        bi_q <= '0;
        k_q  <= LYR_W'(1);
        ii_q <= '0;
        if (cmd_i.qstart) begin
          l_q    <= left_index_i;
          last_q <= IDX_W'(right_end_i - CNT_W'(1));
          err_q  <= !built_q || ({1'b0, left_index_i} >= right_end_i) ||
                    (right_end_i > count_q);
        end
      end
      S_B_START: begin
        j_q     <= base + CNT_W'(1);
        stack_q <= BLOCK_SIZE'(1);
      end
      S_B_VJ:  vj_q <= val_rdata_q;
      S_B_CMP: if (stat_o.pop) stack_q <= stack_q & ~top_bit;
      S_B_BLK: begin
        bi_q <= bi_q + (BLK_W+1)'(1);
        k_q  <= LYR_W'(1);
        ii_q <= '0;
      end
      S_L_START: ii_q <= '0;
      S_L_RD2:   idx1_q <= st_rdata_q;
      S_L_V1:    idx2_q <= st_rdata_q;
      S_L_V2:    best_val_q <= val_rdata_q;
      S_L_WR: begin
        ii_q <= ii_q + (BLK_W+1)'(1);
        if (!stat_o.more_pairs) k_q <= k_q + LYR_W'(1);
      end
      S_Q_M2: begin
        if (lb == rb) best_idx_q <= a_idx;
        else cand_q <= {rb, low_bit(mask_rdata_q)};
      end
      S_Q_A:  best_idx_q <= a_idx;
      S_Q_B:  best_val_q <= val_rdata_q;
      S_Q_BC, S_Q_S4: begin
        if (take) begin
          best_idx_q <= cand_q;
          best_val_q <= val_rdata_q;
        end
      end
      S_Q_S2: cand_q <= st_rdata_q;
      S_Q_S3: begin
        if (take) begin
          best_idx_q <= cand_q;
          best_val_q <= val_rdata_q;
        end
        cand_q <= st_rdata_q;
      end
      default: ;
    endcase
    if (push) begin
      stack_q <= stack_push;
      j_q     <= j_q + CNT_W'(1);
    end
  end

  assign error_o        = err_q;
  assign result_index_o = err_q ? '0 : best_idx_q;

endmodule
`default_nettype wire

// ----- rtl/static_range_minimum_query_unit.sv -----
`default_nettype none
// Range minimum/maximum query over a loaded array of up to 1024 values.
// Input channel (in_valid_i/in_ready_o): operation 0 loads value_i at the
// next index; a load with last_i set starts the build. Operation 1 queries
// the half-open range [left_index_i, right_end_i) and yields one result beat
// on the output channel (out_valid_o/out_ready_i): the leftmost extremum's
// index, or error_o with index 0 for an empty, out-of-bounds or unbuilt
// query. Loads produce no result.
// Config channel (cfg_valid_i/cfg_ready_o): select_maximum_i picks max mode;
// if the array is built, the write reruns the build for the new mode.
// A query ends at the error check, within one block or across two blocks,
// or reads the block table for a wider range, and then waits on the output
// handshake; one item is in flight at a time and the input is
// not ready until the result beat is taken, so a stalled receiver holds it.
// The build walks each element through one shared value-memory read port,
// with one more read per stack pop, then fills each table entry from two
// entries of the layer below; no items are taken meanwhile.
// Reset clears the count, the built flag and the mode; memories are unset.
module static_range_minimum_query_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              operation_i,
  input  wire logic [srmq_pkg::VALUE_WIDTH-1:0]  value_i,
  input  wire logic                              last_i,
  input  wire logic [srmq_pkg::IDX_W-1:0]        left_index_i,
  input  wire logic [srmq_pkg::CNT_W-1:0]        right_end_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [srmq_pkg::IDX_W-1:0]             result_index_o,
  output logic                                   error_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic                              select_maximum_i
);
  import srmq_pkg::*;

  srmq_cmd_t  cmd;
  srmq_stat_t stat;

  srmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .last_i      (last_i),
    .cfg_valid_i (cfg_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  srmq_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .value_i          (value_i),
    .left_index_i     (left_index_i),
    .right_end_i      (right_end_i),
    .select_maximum_i (select_maximum_i),
    .stat_o           (stat),
    .result_index_o   (result_index_o),
    .error_o          (error_o)
  );

endmodule
`default_nettype wire

// ----- rtl/srmq_checker.sv -----
`default_nettype none
`include "static_range_minimum_query_unit_macros.svh"
module srmq_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic                             operation_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [srmq_pkg::IDX_W-1:0]       result_index_o,
  input wire logic                             error_o,
  input wire logic                             cfg_ready_o
);
  import srmq_pkg::*;

  // a held result beat keeps its payload
  `SRMQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_index_o) && $stable(error_o))
  // an error beat carries index zero
  `SRMQ_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && error_o, result_index_o == '0)
  // no new item while a result waits
  `SRMQ_ASSERT_IMP(a_one_item, clk_i, rst_ni, out_valid_o, !in_ready_o && !cfg_ready_o)
  // an accepted query closes the input until its result is out
  `SRMQ_ASSERT_NXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (operation_i == OP_QUERY), !in_ready_o && !out_valid_o)

endmodule

bind static_range_minimum_query_unit srmq_checker u_srmq_checker (.*);
`default_nettype wire
